// ===== rtl/salru_pkg.sv =====
// ============================================================================
// salru_pkg
// Shared types and constants for the set-associative true-LRU replacement block.
// ============================================================================
`default_nettype none

package salru_pkg;

    // Default geometry.
    localparam int WAYS_DEF     = 4;
    localparam int NUM_SETS_DEF = 64;

    // Fixed field widths of one beat.
    localparam int ADDR_W      = 32;
    localparam int WAY_FIELD_W = 2;
    localparam int MASK_W      = 4;
    localparam int OFFSET_W    = 4;

    // Configuration port geometry: one 32-bit register at byte address 0.
    localparam int APB_DATA_W  = 32;
    localparam int PADDR_W     = 3;
    localparam int REG_IDX_W   = PADDR_W - 2;

    localparam logic [OFFSET_W-1:0] LINE_OFFSET_RST = OFFSET_W'(6);

    typedef enum logic {
        OP_QUERY = 1'b0,
        OP_TOUCH = 1'b1
    } salru_op_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_LINE_OFFSET = REG_IDX_W'(0)
    } salru_reg_t;

    // One request as it travels down the pipeline.
    typedef struct packed {
        salru_op_t               op;
        logic [WAY_FIELD_W-1:0]  way;
        logic [MASK_W-1:0]       mask;
    } salru_item_t;

    // Flow status from the recency core back to the set index stages.
    typedef struct packed {
        logic ready;
        logic clearing;
    } salru_flow_t;

endpackage

`default_nettype wire

// ===== rtl/salru_cfg.sv =====
// ============================================================================
// salru_cfg
// Configuration register file behind the APB-style port.
// ============================================================================
`default_nettype none

module salru_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [salru_pkg::PADDR_W-1:0]     paddr,
    input  logic [salru_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [salru_pkg::APB_DATA_W-1:0]  prdata,
    output logic [salru_pkg::OFFSET_W-1:0]    line_offset
);
    import salru_pkg::*;

    logic [OFFSET_W-1:0] line_offset_reg;
    logic                wr_en;
    salru_reg_t          reg_idx;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = salru_reg_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_offset_reg <= LINE_OFFSET_RST;
        end else if (wr_en && (reg_idx == REG_LINE_OFFSET)) begin
            line_offset_reg <= pwdata[OFFSET_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LINE_OFFSET: prdata = APB_DATA_W'(line_offset_reg);
            default:         prdata = '0;
        endcase
    end

    assign line_offset = line_offset_reg;

endmodule

`default_nettype wire

// ===== rtl/salru_index.sv =====
// ============================================================================
// salru_index
// Input register and set index stage: shift by the line offset, reduce
// modulo the set count.
// ============================================================================
`default_nettype none

module salru_index #(
    parameter int NUM_SETS = salru_pkg::NUM_SETS_DEF,
    parameter int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [salru_pkg::OFFSET_W-1:0]  line_offset,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  salru_pkg::salru_item_t          in_item,
    input  logic [salru_pkg::ADDR_W-1:0]    in_addr,
    input  salru_pkg::salru_flow_t          flow,
    output logic                            out_valid,
    output salru_pkg::salru_item_t          out_item,
    output logic [SET_W-1:0]                out_set
);
    import salru_pkg::*;

    localparam bit POW2 = (NUM_SETS & (NUM_SETS - 1)) == 0;

    logic               i_vld_reg;
    salru_item_t        i_item_reg;
    logic [ADDR_W-1:0]  i_addr_reg;
    logic               s2_vld_reg;
    salru_item_t        s2_item_reg;
    logic [ADDR_W-1:0]  shifted;
    logic               i_adv;
    logic               s2_adv;

    assign s2_adv   = s2_vld_reg & flow.ready;
    assign i_adv    = i_vld_reg & (~s2_vld_reg | s2_adv);
    assign in_ready = ~flow.clearing & (~i_vld_reg | i_adv);
    assign shifted  = i_addr_reg >> line_offset;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_vld_reg  <= 1'b0;
            s2_vld_reg <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                i_vld_reg <= 1'b1;
            end else if (i_adv) begin
                i_vld_reg <= 1'b0;
            end
            if (i_adv) begin
                s2_vld_reg <= 1'b1;
            end else if (s2_adv) begin
                s2_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            i_item_reg <= in_item;
            i_addr_reg <= in_addr;
        end
        if (i_adv) begin
            s2_item_reg <= i_item_reg;
        end
    end

    generate
        if (POW2) begin : g_pow2
            // Power-of-two set count: the remainder is a mask.
            logic [SET_W-1:0] set_reg;

            always_ff @(posedge aclk) begin
                if (i_adv) begin
                    set_reg <= SET_W'(shifted & ADDR_W'(NUM_SETS - 1));
                end
            end

            assign out_set = set_reg;
        end else begin : g_recip
            // Quotient estimate by reciprocal; it is low by at most one, so
            // a single compare and subtract fixes the remainder.
            localparam logic [63:0] RECIP = (64'd1 << 32) / NUM_SETS;

            logic [ADDR_W-1:0]   shift_reg;
            logic [ADDR_W-1:0]   quo_reg;
            logic [63:0]         prod;
            logic [ADDR_W-1:0]   diff;
            logic [SET_W:0]      rem;

            assign prod = {32'd0, shifted} * RECIP;

            always_ff @(posedge aclk) begin
                if (i_adv) begin
                    shift_reg <= shifted;
                    quo_reg   <= prod[63:32];
                end
            end

            assign diff = shift_reg - (quo_reg * ADDR_W'(NUM_SETS));
            assign rem  = diff[SET_W:0];
            assign out_set = (rem >= (SET_W + 1)'(NUM_SETS))
                           ? SET_W'(rem - (SET_W + 1)'(NUM_SETS))
                           : rem[SET_W-1:0];
        end
    endgenerate

    assign out_valid = s2_vld_reg;
    assign out_item  = s2_item_reg;

endmodule

`default_nettype wire

// ===== rtl/salru_core.sv =====
// ============================================================================
// salru_core
// Recency order memory with clearing pass, read stage with write forwarding,
// victim and touch logic, and the result register.
// ============================================================================
`default_nettype none

module salru_core #(
    parameter int WAYS     = salru_pkg::WAYS_DEF,
    parameter int NUM_SETS = salru_pkg::NUM_SETS_DEF,
    parameter int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    input  salru_pkg::salru_item_t              in_item,
    input  logic [SET_W-1:0]                    in_set,
    output salru_pkg::salru_flow_t              flow,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [salru_pkg::WAY_FIELD_W-1:0]   out_way,
    output logic                                out_free
);
    import salru_pkg::*;

    localparam int WAY_W = $clog2(WAYS);
    localparam int CMP_W = (WAY_W > WAY_FIELD_W) ? WAY_W : WAY_FIELD_W;
    localparam logic [SET_W-1:0] LAST_SET = SET_W'(NUM_SETS - 1);

    typedef logic [WAYS-1:0][WAY_W-1:0] order_t;

    order_t             mem [NUM_SETS];

    // Clearing pass.
    logic               clr_busy_reg;
    logic [SET_W-1:0]   clr_cnt_reg;
    order_t             ident;

    // Read stage.
    logic               r_vld_reg;
    salru_item_t        r_item_reg;
    logic [SET_W-1:0]   r_set_reg;
    order_t             rdata_reg;
    order_t             r_ord;

    // Most recent write, for the read that saw memory before it landed.
    logic               lw_vld_reg;
    logic [SET_W-1:0]   lw_set_reg;
    order_t             lw_ord_reg;

    // Execute stage.
    logic               e_vld_reg;
    salru_item_t        e_item_reg;
    logic [SET_W-1:0]   e_set_reg;
    order_t             e_ord_reg;
    order_t             e_ord_next;
    order_t             new_ord;
    logic               touch_hit;
    logic [WAY_W-1:0]   hit_pos;
    logic               e_write;
    logic [CMP_W-1:0]   victim_ext;
    logic               victim_free;
    logic [CMP_W-1:0]   way_ext;

    // Result register.
    logic                    m_vld_reg;
    logic [WAY_FIELD_W-1:0]  m_way_reg;
    logic                    m_free_reg;

    logic               e_adv;
    logic               r_adv;
    logic               r_load;
    logic               mem_we;
    logic [SET_W-1:0]   mem_waddr;
    order_t             mem_wdata;

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            ident[i] = WAY_W'(i);
        end
    end

    // ---------------------------------------------------------------- flow
    assign e_adv  = e_vld_reg & ((e_item_reg.op == OP_TOUCH) | ~m_vld_reg | out_ready);
    assign r_adv  = r_vld_reg & (~e_vld_reg | e_adv);
    assign flow.ready    = ~clr_busy_reg & (~r_vld_reg | r_adv);
    assign flow.clearing = clr_busy_reg;
    assign r_load = in_valid & flow.ready;

    // --------------------------------------------------------------- memory
    assign e_write   = e_adv & (e_item_reg.op == OP_TOUCH) & touch_hit;
    assign mem_we    = clr_busy_reg | e_write;
    assign mem_waddr = clr_busy_reg ? clr_cnt_reg : e_set_reg;
    assign mem_wdata = clr_busy_reg ? ident : new_ord;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (r_load) begin
            rdata_reg <= mem[in_set];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            if (clr_cnt_reg == LAST_SET) begin
                clr_busy_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
        end
    end

    // ----------------------------------------------------------- read stage
    assign r_ord = (lw_vld_reg && (lw_set_reg == r_set_reg)) ? lw_ord_reg : rdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_vld_reg  <= 1'b0;
            lw_vld_reg <= 1'b0;
        end else begin
            if (r_load) begin
                r_vld_reg <= 1'b1;
            end else if (r_adv) begin
                r_vld_reg <= 1'b0;
            end
            if (e_write) begin
                lw_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (r_load) begin
            r_item_reg <= in_item;
            r_set_reg  <= in_set;
        end
        if (e_write) begin
            lw_set_reg <= e_set_reg;
            lw_ord_reg <= new_ord;
        end
    end

    // -------------------------------------------------------- execute stage
    assign e_ord_next = (e_write && (e_set_reg == r_set_reg)) ? new_ord : r_ord;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_vld_reg <= 1'b0;
        end else if (r_adv) begin
            e_vld_reg <= 1'b1;
        end else if (e_adv) begin
            e_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (r_adv) begin
            e_item_reg <= r_item_reg;
            e_set_reg  <= r_set_reg;
            e_ord_reg  <= e_ord_next;
        end
    end

    assign way_ext = CMP_W'(e_item_reg.way);

    // Touch: find the way, close the gap, put it at the most recent end.
    always_comb begin
        touch_hit = 1'b0;
        hit_pos   = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (CMP_W'(e_ord_reg[i]) == way_ext) begin
                touch_hit = 1'b1;
                hit_pos   = WAY_W'(i);
            end
        end
        new_ord[WAYS-1] = WAY_W'(way_ext);
        for (int i = 0; i < WAYS - 1; i++) begin
            new_ord[i] = (WAY_W'(i) < hit_pos) ? e_ord_reg[i] : e_ord_reg[i+1];
        end
    end

    // Query: first way in recency order without a valid bit, else the LRU way.
    always_comb begin
        logic [CMP_W-1:0] cand;
        victim_ext  = CMP_W'(e_ord_reg[0]);
        victim_free = 1'b0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            cand = CMP_W'(e_ord_reg[i]);
            if ((cand > CMP_W'(MASK_W - 1)) || !e_item_reg.mask[cand[1:0]]) begin
                victim_ext  = cand;
                victim_free = 1'b1;
            end
        end
    end

    // ------------------------------------------------------ result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (e_adv && (e_item_reg.op == OP_QUERY)) begin
            m_vld_reg <= 1'b1;
        end else if (out_ready) begin
            m_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (e_adv && (e_item_reg.op == OP_QUERY)) begin
            m_way_reg  <= victim_ext[WAY_FIELD_W-1:0];
            m_free_reg <= victim_free;
        end
    end

    assign out_valid = m_vld_reg;
    assign out_way   = m_way_reg;
    assign out_free  = m_free_reg;

endmodule

`default_nettype wire

// ===== rtl/set_assoc_lru_replacement_top.sv =====
// ============================================================================
// set_assoc_lru_replacement_top
// True-LRU replacement state for a set-associative cache.
// ============================================================================
// The block keeps one recency order of WAYS ways for each of NUM_SETS sets.
// A query beat (tuser = 0) picks the first way without a valid bit in
// recency order, or else the least recent way, and returns one result beat;
// a touch beat (tuser = 1) moves its way to the most recent position and
// returns nothing. The set is (address >> line_offset_bits) mod NUM_SETS.
// One beat is taken every clock cycle while no clearing pass runs and no
// query waits on a stalled result; a query passes the input register, the
// set index stage, the registered read of the order memory and the execute
// stage before the result register. Back-to-back beats to the same set see
// each other's updates through forwarding, so no bubbles are inserted.
// After reset the block writes the initial order into every set, one set
// per cycle, and holds s_tready low until the pass ends; register writes are
// taken throughout. A stalled result stops touch beats only behind a query.
// ============================================================================
`default_nettype none

module set_assoc_lru_replacement_top #(
    parameter int WAYS     = salru_pkg::WAYS_DEF,
    parameter int NUM_SETS = salru_pkg::NUM_SETS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Request channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] address, [33:32] way, [37:34] valid_mask, [39:38] zero
    input  logic [39:0]                       s_tdata,
    // [0] operation
    input  logic [0:0]                        s_tuser,

    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] victim_way, [2] victim_was_free, [7:3] zero
    output logic [7:0]                        m_tdata,

    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [salru_pkg::PADDR_W-1:0]     paddr,
    input  logic [salru_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [salru_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);
    import salru_pkg::*;

    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

    logic [OFFSET_W-1:0]    line_offset;
    salru_item_t            s_item;
    salru_flow_t            flow;
    logic                   idx_valid;
    salru_item_t            idx_item;
    logic [SET_W-1:0]       idx_set;
    logic [WAY_FIELD_W-1:0] victim_way;
    logic                   victim_free;

    // Registers complete in the access cycle.
    assign pready = 1'b1;

    assign s_item.op   = salru_op_t'(s_tuser[0]);
    assign s_item.way  = s_tdata[33:32];
    assign s_item.mask = s_tdata[37:34];

    salru_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .line_offset (line_offset)
    );

    salru_index #(
        .NUM_SETS (NUM_SETS),
        .SET_W    (SET_W)
    ) u_index (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .line_offset (line_offset),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_item     (s_item),
        .in_addr     (s_tdata[31:0]),
        .flow        (flow),
        .out_valid   (idx_valid),
        .out_item    (idx_item),
        .out_set     (idx_set)
    );

    salru_core #(
        .WAYS     (WAYS),
        .NUM_SETS (NUM_SETS),
        .SET_W    (SET_W)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (idx_valid),
        .in_item   (idx_item),
        .in_set    (idx_set),
        .flow      (flow),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_way   (victim_way),
        .out_free  (victim_free)
    );

    assign m_tdata = {5'd0, victim_free, victim_way};

endmodule

`default_nettype wire

// ===== rtl/salru_checker.sv =====
// ============================================================================
// salru_port_checker
// Port-level assertions for the LRU replacement block, bound to the top.
// ============================================================================
`default_nettype none

module salru_port_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // The clearing pass always follows reset, so no beat is taken right after it.
    a_clear_after_reset: assert property (
        @(posedge aclk) $past(!aresetn) |-> !s_tready
    ) else $error("request taken before the order memory was cleared");

    a_no_result_after_reset: assert property (
        @(posedge aclk) !aresetn |=> !m_tvalid
    ) else $error("result beat present right after reset");

    a_result_held: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata))
    ) else $error("stalled result beat changed or dropped");

    a_result_padding: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:3] == 5'd0)
    ) else $error("result beat has nonzero padding");

endmodule

bind set_assoc_lru_replacement_top salru_port_checker u_checker (.*);

`default_nettype wire
